>>> rtl/core/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants of the word phrase matcher
// Operation codes, field widths and the control and result bundles that
// pass between the top level, the match cells and the output stage.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int unsigned WordWidth         = 32;
  localparam int unsigned CountWidth        = 32;
  localparam int unsigned MaxPhraseDefault  = 64;

  typedef enum logic {
    OpLoad   = 1'b0,
    OpSearch = 1'b1
  } op_e;

  // Broadcast to every match cell in the chain.
  typedef struct packed {
    logic                 load_en;
    logic                 search_en;
    logic                 restart;
    logic                 last;
    logic [WordWidth-1:0] word;
  } cell_ctrl_t;

  typedef struct packed {
    logic                  matched;
    logic [CountWidth-1:0] sentence_number;
    logic                  phrase_overflow;
  } result_t;

endpackage

>>> rtl/core/wpm_cell.sv
// ----------------------------------------------------------------------------
// wpm_cell: one match cell of the phrase chain
// Holds one phrase word, its occupied flag and one partial-match bit; takes
// the left neighbor's flags and hands its own to the right in every cycle.
// ----------------------------------------------------------------------------
module wpm_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wpm_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                prev_active_i,
  input  logic                                prev_hit_i,
  input  logic                                next_active_i,
  output logic                                active_o,
  output logic                                hit_o,
  output logic                                tail_hit_o
);

  logic                          active_q, active_d;
  logic                          hit_q, hit_d;
  logic [wpm_pkg::WordWidth-1:0] word_q;
  logic                          write_en;
  logic                          hit_calc;

  // Occupied flag as seen after a load restart has emptied the chain.
  assign active_o = active_q & ~ctrl_i.restart;

  // Fill the first free cell: left neighbor occupied, this one free.
  assign write_en = ctrl_i.load_en & prev_active_i & ~active_o;
  assign active_d = active_o | write_en;

  assign hit_calc = active_q & prev_hit_i & (word_q == ctrl_i.word);

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.restart) begin
      hit_d = 1'b0;
    end else if (ctrl_i.search_en) begin
      hit_d = ctrl_i.last ? 1'b0 : hit_calc;
    end
  end

  // Full phrase seen when the last occupied cell hits.
  assign tail_hit_o = ctrl_i.search_en & hit_calc & ~next_active_i;
  assign hit_o      = hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      active_q <= active_d;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_en) begin
      word_q <= ctrl_i.word;
    end
  end

endmodule

>>> rtl/core/wpm_out_stage.sv
// ----------------------------------------------------------------------------
// wpm_out_stage: result register with valid/stall handshake
// Holds one result until the receiver takes it; frees the slot in the same
// cycle as the transfer.
// ----------------------------------------------------------------------------
module wpm_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wpm_pkg::result_t    result_i,
  output logic                busy_o,
  output logic                valid_o,
  input  logic                stall_i,
  output wpm_pkg::result_t    result_o
);

  logic             valid_q, valid_d;
  wpm_pkg::result_t result_q;

  assign busy_o  = valid_q & stall_i;
  assign valid_d = push_i | busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

>>> rtl/core/word_phrase_matcher.sv
// ----------------------------------------------------------------------------
// word_phrase_matcher: contiguous phrase search over a word-id stream
// Shift-and matcher built as a chain of match cells, one per phrase word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries op_i, word_id_i, last_i.
//   Load transfers (op 0) store the phrase one word per cell; the first load
//   after a finished load or search word clears chain and sentence counter.
//   Search transfers (op 1) carry one sentence word each. All alignments are
//   updated in parallel: every cell compares its word with the broadcast
//   word and ANDs the result with its left neighbor's partial-match bit.
//   On the last word of a sentence one result (matched_o, sentence_number_o,
//   phrase_overflow_o) appears on the output channel (out_valid_o /
//   out_stall_i) in the cycle after the transfer.
//   Throughput is one word per cycle while in_stall_o is low.
//   The input stalls only while a result waits in the output register and
//   the receiver stalls; items without a result still need that slot free.
//   Reset empties the phrase (every sentence then matches), clears the
//   counter, the overflow flag and the output valid flag. Phrase words beyond
//   MaxPhrase are dropped and flag overflow; no sentence matches then.
// ----------------------------------------------------------------------------
module word_phrase_matcher #(
  parameter int unsigned MaxPhrase = wpm_pkg::MaxPhraseDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [wpm_pkg::WordWidth-1:0]   word_id_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            matched_o,
  output logic [wpm_pkg::CountWidth-1:0]  sentence_number_o,
  output logic                            phrase_overflow_o
);

  logic                           in_xfer;
  logic                           is_load, is_search;
  wpm_pkg::cell_ctrl_t            ctrl;
  wpm_pkg::result_t               result_d, result_q;

  // Flag chains: index 0 is the fixed left boundary, index k+1 is cell k.
  logic [MaxPhrase:0]             active_chain;
  logic [MaxPhrase:0]             hit_chain;
  logic [MaxPhrase-1:0]           next_active;
  logic [MaxPhrase-1:0]           tail_hits;
  logic                           any_tail_hit;

  logic                           load_done_q, load_done_d;
  logic                           overflow_q, overflow_d;
  logic                           found_q, found_d;
  logic [wpm_pkg::CountWidth-1:0] count_q, count_d;
  logic                           push;
  logic                           out_busy;

  assign in_xfer    = in_valid_i & ~out_busy;
  assign in_stall_o = out_busy;
  assign is_load    = in_xfer & (op_i == wpm_pkg::OpLoad);
  assign is_search  = in_xfer & (op_i == wpm_pkg::OpSearch);

  assign ctrl.load_en   = is_load;
  assign ctrl.search_en = is_search;
  assign ctrl.restart   = is_load & load_done_q;
  assign ctrl.last      = last_i;
  assign ctrl.word      = word_id_i;

  // Cell 0 always sees an occupied left neighbor holding a full match.
  assign active_chain[0] = 1'b1;
  assign hit_chain[0]    = 1'b1;

  for (genvar k = 0; k < MaxPhrase; k++) begin : g_cell
    if (k == MaxPhrase - 1) begin : g_edge
      assign next_active[k] = 1'b0;
    end else begin : g_inner
      assign next_active[k] = active_chain[k+2];
    end

    wpm_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .prev_active_i (active_chain[k]),
      .prev_hit_i    (hit_chain[k]),
      .next_active_i (next_active[k]),
      .active_o      (active_chain[k+1]),
      .hit_o         (hit_chain[k+1]),
      .tail_hit_o    (tail_hits[k])
    );
  end

  assign any_tail_hit = |tail_hits;

  // Track load state, overflow, per-sentence match and sentence count.
  always_comb begin
    load_done_d = load_done_q;
    overflow_d  = overflow_q;
    found_d     = found_q;
    count_d     = count_q;
    if (is_load) begin
      load_done_d = last_i;
      // Last cell already occupied after restart masking: drop the word.
      overflow_d  = (overflow_q & ~ctrl.restart) | active_chain[MaxPhrase];
      if (ctrl.restart) begin
        found_d = 1'b0;
        count_d = '0;
      end
    end else if (is_search) begin
      load_done_d = 1'b1;
      if (last_i) begin
        found_d = 1'b0;
        count_d = count_q + wpm_pkg::CountWidth'(1);
      end else begin
        found_d = found_q | any_tail_hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_done_q <= 1'b1;
      overflow_q  <= 1'b0;
      found_q     <= 1'b0;
      count_q     <= '0;
    end else begin
      load_done_q <= load_done_d;
      overflow_q  <= overflow_d;
      found_q     <= found_d;
      count_q     <= count_d;
    end
  end

  // An empty chain means an empty phrase, which matches every sentence.
  assign push                     = is_search & last_i;
  assign result_d.matched         = ~overflow_q
                                    & (~active_chain[1] | found_q | any_tail_hit);
  assign result_d.sentence_number = count_q;
  assign result_d.phrase_overflow = overflow_q;

  wpm_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .result_i (result_d),
    .busy_o   (out_busy),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .result_o (result_q)
  );

  assign matched_o         = result_q.matched;
  assign sentence_number_o = result_q.sentence_number;
  assign phrase_overflow_o = result_q.phrase_overflow;

endmodule

>>> tb/tb_word_phrase_matcher.sv
// ----------------------------------------------------------------------------
// tb_word_phrase_matcher: self-checking bench for the word phrase matcher
// Streams phrase loads and sentence words into the block with random gaps on
// both channels. A behavioral shift-and tracker predicts one verdict per
// finished sentence, and the monitor checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_word_phrase_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PHRASE  = wpm_pkg::MaxPhraseDefault;
  localparam int unsigned WORD_TARGET = 1100;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned MAX_WAIT    = 17;
  // Receiver hold-off: starts after this many input transfers, lasts this long.
  localparam int unsigned HOLD_AFTER  = 500;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    wpm_pkg::op_e                  op;
    logic [wpm_pkg::WordWidth-1:0] word;
    logic                          last;
  } word_item_t;

  // DUT connections
  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic                           op_i = 1'b0;
  logic [wpm_pkg::WordWidth-1:0]  word_id_i = '0;
  logic                           last_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic                           matched_o;
  logic [wpm_pkg::CountWidth-1:0] sentence_number_o;
  logic                           phrase_overflow_o;

  // Stimulus side
  word_item_t                    word_stream[$];
  logic [wpm_pkg::WordWidth-1:0] gen_phrase[$];   // phrase as the generator last loaded it
  int unsigned                   n_generated = 0;
  word_item_t                    tx_item;
  int unsigned                   tx_gap = 0;

  // Prediction side: shadow of the matcher state
  logic [wpm_pkg::WordWidth-1:0]  sh_phrase[MAX_PHRASE];
  int unsigned                    sh_len = 0;
  logic                           sh_load_done = 1'b1;
  logic [MAX_PHRASE-1:0]          sh_hits = '0;
  logic                           sh_found = 1'b0;
  logic [wpm_pkg::CountWidth-1:0] sh_count = '0;
  logic                           sh_overflow = 1'b0;
  wpm_pkg::result_t               sentence_verdicts[$];

  // Monitor side
  word_item_t       rx_item;
  wpm_pkg::result_t want;
  int unsigned      rx_wait = 0;
  int unsigned      n_taken = 0;
  int unsigned      n_errors = 0;
  int unsigned      hold_left = 0;
  logic             hold_started = 1'b0;
  int unsigned      cycle_count = 0;

  word_phrase_matcher #(
    .MaxPhrase(MAX_PHRASE)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .word_id_i        (word_id_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .matched_o        (matched_o),
    .sentence_number_o(sentence_number_o),
    .phrase_overflow_o(phrase_overflow_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Idle draw shared by both channels. Calm stretches with no idling at all
  // recur, so back-to-back transfers get covered.
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_wait();
    if ((cycle_count % 3000) < 700) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, MAX_WAIT);
    return 0;
  endfunction

  // Mostly a tiny vocabulary so phrases actually show up in sentences; the
  // extremes and fully random words keep every bit of word_id toggling.
  function automatic logic [wpm_pkg::WordWidth-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return wpm_pkg::WordWidth'(r % 4);
    if (r == 6) return '0;
    if (r == 7) return '1;
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic queue_word(input wpm_pkg::op_e op,
                            input logic [wpm_pkg::WordWidth-1:0] word,
                            input logic last);
    word_item_t it;
    it.op   = op;
    it.word = word;
    it.last = last;
    word_stream.push_back(it);
    n_generated++;
  endtask

  // Load a phrase; with finish=0 the load is left open on purpose.
  task automatic load_phrase(input logic [wpm_pkg::WordWidth-1:0] words[$],
                             input bit finish);
    gen_phrase.delete();
    foreach (words[i]) begin
      if (i < MAX_PHRASE) gen_phrase.push_back(words[i]);
      queue_word(wpm_pkg::OpLoad, words[i], finish && (i == words.size() - 1));
    end
  endtask

  task automatic send_sentence(input logic [wpm_pkg::WordWidth-1:0] words[$]);
    foreach (words[i]) queue_word(wpm_pkg::OpSearch, words[i], i == words.size() - 1);
  endtask

  task automatic random_phrase(input int unsigned len, input bit finish);
    logic [wpm_pkg::WordWidth-1:0] words[$];
    repeat (len) words.push_back(pick_word());
    load_phrase(words, finish);
  endtask

  // Random sentence; half of the time the current phrase is planted in it,
  // sometimes with its final word disturbed to give a near miss.
  task automatic random_sentence();
    logic [wpm_pkg::WordWidth-1:0] words[$];
    int unsigned n;
    int unsigned pos;
    int unsigned plen;
    bit plant;
    n    = $urandom_range(1, 10);
    plen = gen_phrase.size();
    plant = (plen != 0) && ($urandom_range(0, 1) == 1);
    if (plant && plen > n) n = plen + $urandom_range(0, 3);
    pos = plant ? $urandom_range(0, n - plen) : 0;
    for (int i = 0; i < n; i++) begin
      if (plant && i >= pos && i < pos + plen) words.push_back(gen_phrase[i - pos]);
      else words.push_back(pick_word());
    end
    if (plant && $urandom_range(0, 5) == 0)
      words[pos + plen - 1] = words[pos + plen - 1]
                              ^ (wpm_pkg::WordWidth'(1) << $urandom_range(0, 31));
    send_sentence(words);
  endtask

  task automatic build_stream();
    int unsigned r;
    int unsigned n_long = 0;

    // Empty phrase straight out of reset: every sentence matches.
    send_sentence('{32'h0000_0000});
    send_sentence('{32'hFFFF_FFFF});
    // Load restart, then a hit on the alignment ending on the final word, and a miss.
    load_phrase('{32'hFFFF_FFFF, 32'h0000_0000}, 1);
    send_sentence('{32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0000});
    send_sentence('{32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0000});
    // Open load closed by a sentence word.
    load_phrase('{32'h0000_0007}, 0);
    send_sentence('{32'h0000_0007});
    // A load in the middle of a sentence drops that sentence.
    queue_word(wpm_pkg::OpSearch, 32'h0000_0007, 1'b0);
    load_phrase('{32'h0000_0009}, 1);
    send_sentence('{32'h0000_0009});

    while (n_generated < WORD_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        random_phrase($urandom_range(1, 6), 1);
      end else if (r < 8 && n_long < 4) begin
        // Phrase at full capacity, or past it (overflow, never matches).
        n_long++;
        random_phrase((n_long % 2 == 1) ? MAX_PHRASE
                                        : $urandom_range(MAX_PHRASE + 1, MAX_PHRASE + 4),
                      1);
        random_sentence();
      end else if (r < 11) begin
        random_phrase($urandom_range(1, 4), 0);
        random_sentence();
      end else if (r < 14) begin
        repeat ($urandom_range(1, 3)) queue_word(wpm_pkg::OpSearch, pick_word(), 1'b0);
        random_phrase($urandom_range(1, 5), 1);
      end else begin
        random_sentence();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Shift-and tracker: update the shadow state with one accepted word and
  // queue a verdict when a sentence finishes.
  // --------------------------------------------------------------------------
  task automatic track_phrase_match(input word_item_t it);
    logic [MAX_PHRASE-1:0] hits_next;
    wpm_pkg::result_t      verdict;
    if (it.op == wpm_pkg::OpLoad) begin
      if (sh_load_done) begin
        sh_len       = 0;
        sh_overflow  = 1'b0;
        sh_count     = '0;
        sh_hits      = '0;
        sh_found     = 1'b0;
        sh_load_done = 1'b0;
      end
      if (sh_len < MAX_PHRASE) begin
        sh_phrase[sh_len] = it.word;
        sh_len++;
      end else begin
        sh_overflow = 1'b1;
      end
      if (it.last) sh_load_done = 1'b1;
    end else begin
      sh_load_done = 1'b1;
      hits_next = '0;
      for (int k = 0; k < sh_len; k++)
        hits_next[k] = ((k == 0) ? 1'b1 : sh_hits[k-1]) && (sh_phrase[k] == it.word);
      sh_hits = hits_next;
      if (sh_len > 0 && sh_hits[sh_len-1]) sh_found = 1'b1;
      if (it.last) begin
        verdict.matched         = !sh_overflow && (sh_len == 0 || sh_found);
        verdict.sentence_number = sh_count;
        verdict.phrase_overflow = sh_overflow;
        sentence_verdicts.push_back(verdict);
        sh_count = sh_count + wpm_pkg::CountWidth'(1);
        sh_hits  = '0;
        sh_found = 1'b0;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer words from the stream, with a random wait drawn per word.
  // A stalled transfer keeps its payload and valid untouched.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i       <= wpm_pkg::OpLoad;
      word_id_i  <= '0;
      last_i     <= 1'b0;
      tx_gap     <= 0;
    end else if (in_valid_i && in_stall_o) begin
      // hold the current transfer
    end else if (tx_gap != 0) begin
      in_valid_i <= 1'b0;
      tx_gap     <= tx_gap - 1;
    end else if (word_stream.size() != 0) begin
      tx_item    = word_stream.pop_front();
      op_i       <= tx_item.op;
      word_id_i  <= tx_item.word;
      last_i     <= tx_item.last;
      in_valid_i <= 1'b1;
      tx_gap     <= draw_wait();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted here: once enough words went in, stall
  // the output for a long stretch while the driver keeps offering, so the
  // result register fills and the input side must stall too.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      hold_started <= 1'b0;
    end else if (!hold_started && n_taken >= HOLD_AFTER) begin
      hold_left    <= HOLD_CYCLES;
      hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict from input transfers first, then check result transfers
  // against the oldest pending verdict. The order inside this one process
  // keeps the outcome independent of scheduling between processes.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
      n_taken <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        rx_item.op   = wpm_pkg::op_e'(op_i);
        rx_item.word = word_id_i;
        rx_item.last = last_i;
        track_phrase_match(rx_item);
        n_taken <= n_taken + 1;
      end

      if (out_valid_o && !out_stall_i) begin
        if (sentence_verdicts.size() == 0) begin
          $error("unexpected result: matched %0d sentence_number %0d phrase_overflow %0d",
                 matched_o, sentence_number_o, phrase_overflow_o);
          n_errors++;
        end else begin
          want = sentence_verdicts.pop_front();
          if (matched_o !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, matched_o);
            n_errors++;
          end
          if (sentence_number_o !== want.sentence_number) begin
            $error("sentence_number: expected %0d, actual %0d",
                   want.sentence_number, sentence_number_o);
            n_errors++;
          end
          if (phrase_overflow_o !== want.phrase_overflow) begin
            $error("phrase_overflow: expected %0d, actual %0d",
                   want.phrase_overflow, phrase_overflow_o);
            n_errors++;
          end
        end
        rx_wait = draw_wait();
      end else if (rx_wait != 0) begin
        rx_wait = rx_wait - 1;
      end

      out_stall_i <= (rx_wait != 0) || (hold_left != 0);
    end
  end

  // Watchdog: abort a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("word_phrase_matcher regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build the stream, reset once, then wait for the stream and the
  // pending verdicts to drain before the final verdict.
  // --------------------------------------------------------------------------
  initial begin
    build_stream();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (word_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    while (sentence_verdicts.size() != 0) @(posedge clk_i);
    // the result is registered; leave room for any stray transfer
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("word_phrase_matcher regression: pass");
    end else begin
      $display("word_phrase_matcher regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/wpm_pkg.sv
rtl/core/wpm_cell.sv
rtl/core/wpm_out_stage.sv
rtl/core/word_phrase_matcher.sv
tb/tb_word_phrase_matcher.sv
